// ===== rtl/oprs_pkg.sv =====
`default_nettype none

package oprs_pkg;

    // Default geometry of the frame buffer.
    localparam int PAGES_DEFAULT   = 4;
    localparam int COLUMNS_DEFAULT = 128;

    // Init command list.
    localparam int INIT_LEN       = 34;
    localparam int CONTRAST_POS   = 25;
    localparam int BRIGHTNESS_POS = 27;
    localparam int RUN_CNT_W      = $clog2(INIT_LEN);

    localparam logic [7:0] INIT_TABLE [INIT_LEN] = '{
        8'h00, 8'hAE, 8'hD5, 8'h10, 8'hA8, 8'h1F, 8'hD3, 8'h00, 8'h40, 8'hAD, 8'h8E, 8'hD8,
        8'h05, 8'h20, 8'h02, 8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h91, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
        8'h81, 8'hBF, 8'h82, 8'hBF, 8'hD9, 8'hD2, 8'hDB, 8'h08, 8'hA4, 8'hA6
    };

    // Link bytes used by the refresh runs.
    localparam logic [7:0] CMD_STREAM   = 8'h00;
    localparam logic [7:0] DATA_STREAM  = 8'h40;
    localparam logic [7:0] SET_PAGE     = 8'hB0;
    localparam logic [7:0] SET_COL_LOW  = 8'h00;
    localparam logic [7:0] SET_COL_HIGH = 8'h10;
    localparam logic [7:0] DISPLAY_ON   = 8'hAF;

    // Configuration registers and their reset values.
    typedef enum logic [1:0] {
        REG_COLUMN_OFFSET = 2'd0,
        REG_CONTRAST      = 2'd1,
        REG_BRIGHTNESS    = 2'd2
    } t_reg_idx;

    localparam logic [3:0] COLUMN_OFFSET_RST = 4'd4;
    localparam logic [7:0] CONTRAST_RST      = 8'd191;
    localparam logic [7:0] BRIGHTNESS_RST    = 8'd191;

    typedef struct packed {
        logic [3:0] column_offset;
        logic [7:0] contrast_level;
        logic [7:0] brightness_level;
    } t_cfg;

    // Operation codes of an input transaction.
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_INIT   = 2'd1,
        OP_REDRAW = 2'd2,
        OP_DONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] operation;
        logic [8:0] buffer_index;
        logic [7:0] pixel_byte;
    } t_in_item;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] link_byte;
        logic       last_byte;
        logic       request_accepted;
        logic       frame_done;
        logic       ready_res;
    } t_out_item;

    // Classified command handed from the front to the back through the queue.
    typedef struct packed {
        t_op        op;
        logic       wr_hit;
        logic [8:0] wr_index;
        logic [7:0] wr_pixel;
    } t_cmd;

    // Display-level state.
    typedef enum logic [4:0] {
        SYS_IDLE   = 5'b00001,
        SYS_INIT   = 5'b00010,
        SYS_DRAW   = 5'b00100,
        SYS_DISPON = 5'b01000,
        SYS_WAIT   = 5'b10000
    } t_sys;

    // Refresh progress state.
    typedef enum logic [2:0] {
        DRW_IDLE   = 3'b001,
        DRW_PARAMS = 3'b010,
        DRW_DATA   = 3'b100
    } t_draw;

    // Back-end sequencer state.
    typedef enum logic [2:0] {
        BK_CLEAR = 3'b001,
        BK_IDLE  = 3'b010,
        BK_EMIT  = 3'b100
    } t_bk;

    // Kind of byte run being emitted.
    typedef enum logic [2:0] {
        RUN_NONE   = 3'd0,
        RUN_INIT   = 3'd1,
        RUN_PARAMS = 3'd2,
        RUN_DATA   = 3'd3,
        RUN_DISPON = 3'd4
    } t_run;

    // Byte k of the init list with the configured contrast and brightness.
    function automatic logic [7:0] init_byte(input logic [RUN_CNT_W-1:0] k,
                                             input logic [7:0] contrast,
                                             input logic [7:0] bright);
        logic [7:0] b;
        b = 8'h00;
        if (k == RUN_CNT_W'(CONTRAST_POS)) begin
            b = contrast;
        end else if (k == RUN_CNT_W'(BRIGHTNESS_POS)) begin
            b = bright;
        end else if (int'(k) < INIT_LEN) begin
            b = INIT_TABLE[k];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/oled_page_refresh_sequencer_core.sv =====
`default_nettype none

// Page refresh sequencer for a page-organized monochrome OLED panel. It holds a
// PAGES x COLUMNS byte frame buffer and turns each input transaction (buffer
// write, start init, redraw request, transfer done) into one run of link bytes,
// one output transaction per byte, the last marked by last_byte; a transaction
// that sends no byte still returns one status transaction with byte_valid low.
// A transaction waits in a two-entry queue; once it leaves, its result bytes go
// out through the output register at one byte per cycle when the output side
// does not stall. A status-only transaction gives one status item, a column data
// run two bytes, a page command run four and the init list 34. After reset the
// buffer is cleared in a pass over all PAGES*COLUMNS bytes (512 by default) during
// which no input is accepted; the first transfer done after start init runs the
// same clearing pass before its run is sent. Configuration registers sit on the
// APB port at 0x0 (column offset), 0x4 (contrast) and 0x8 (brightness).
module oled_page_refresh_sequencer_core #(
    parameter int PAGES   = oprs_pkg::PAGES_DEFAULT,
    parameter int COLUMNS = oprs_pkg::COLUMNS_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire oprs_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output oprs_pkg::t_out_item      o_out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [3:0]       r_column_offset;
    logic [7:0]       r_contrast;
    logic [7:0]       r_brightness;
    logic             w_cfg_wr;
    logic [1:0]       w_reg_idx;
    oprs_pkg::t_cfg   w_cfg;

    logic             w_q_valid;
    oprs_pkg::t_cmd   w_q_cmd;
    logic             w_q_pop;
    logic             w_boot_clear;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[3:2];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_offset <= oprs_pkg::COLUMN_OFFSET_RST;
            r_contrast      <= oprs_pkg::CONTRAST_RST;
            r_brightness    <= oprs_pkg::BRIGHTNESS_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                oprs_pkg::REG_COLUMN_OFFSET: r_column_offset <= pwdata[3:0];
                oprs_pkg::REG_CONTRAST:      r_contrast      <= pwdata[7:0];
                oprs_pkg::REG_BRIGHTNESS:    r_brightness    <= pwdata[7:0];
                default:                     r_column_offset <= r_column_offset;
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        unique case (w_reg_idx)
            oprs_pkg::REG_COLUMN_OFFSET: prdata = {28'd0, r_column_offset};
            oprs_pkg::REG_CONTRAST:      prdata = {24'd0, r_contrast};
            oprs_pkg::REG_BRIGHTNESS:    prdata = {24'd0, r_brightness};
            default:                     prdata = 32'd0;
        endcase
    end

    always_comb begin
        w_cfg.column_offset    = r_column_offset;
        w_cfg.contrast_level   = r_contrast;
        w_cfg.brightness_level = r_brightness;
    end

    // Front: accept and classify transactions into the command queue.
    oprs_front #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_hold     (w_boot_clear),
        .o_q_valid  (w_q_valid),
        .o_q_cmd    (w_q_cmd),
        .i_q_pop    (w_q_pop)
    );

    // Back: frame buffer, display sequencing and link byte emission.
    oprs_back #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .o_q_pop      (w_q_pop),
        .o_boot_clear (w_boot_clear),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

    // A status-only transaction always closes its run.
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.byte_valid) |-> o_out_item.last_byte)
        else $error("status transaction without last_byte");

    // An accepted redraw starts a refresh, so it neither ends a frame nor reports ready.
    a_accept_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.request_accepted)
            |-> (!o_out_item.ready_res && !o_out_item.frame_done))
        else $error("accepted redraw reported ready or frame done");

    // No input is taken during the clearing pass after reset.
    a_no_accept_in_boot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_boot_clear |-> !o_in_ready)
        else $error("input accepted during clearing pass");

    // A contrast write lands in its register.
    a_contrast_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && (w_reg_idx == oprs_pkg::REG_CONTRAST))
            |=> (r_contrast == $past(pwdata[7:0])))
        else $error("contrast register write lost");

endmodule

`default_nettype wire

// ===== rtl/oprs_front.sv =====
`default_nettype none

module oprs_front #(
    parameter int PAGES   = oprs_pkg::PAGES_DEFAULT,
    parameter int COLUMNS = oprs_pkg::COLUMNS_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire oprs_pkg::t_in_item i_in_item,
    input  wire logic              i_hold,
    output logic                   o_q_valid,
    output oprs_pkg::t_cmd         o_q_cmd,
    input  wire logic              i_q_pop
);

    localparam int BUF_SIZE = PAGES * COLUMNS;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    oprs_pkg::t_cmd       w_cmd;
    oprs_pkg::t_cmd       r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_push;
    logic                 w_pop;

    // Classify the incoming transaction.
    always_comb begin
        w_cmd.op       = oprs_pkg::t_op'(i_in_item.operation);
        w_cmd.wr_hit   = int'(i_in_item.buffer_index) < BUF_SIZE;
        w_cmd.wr_index = i_in_item.buffer_index;
        w_cmd.wr_pixel = i_in_item.pixel_byte;
    end

    assign o_in_ready = (r_count != Q_CNT_W'(Q_DEPTH)) && !i_hold;
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_valid  = r_count != '0;
    assign o_q_cmd    = r_q[r_rd_ptr];

    // Command queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/oprs_back.sv =====
`default_nettype none

module oprs_back #(
    parameter int PAGES   = oprs_pkg::PAGES_DEFAULT,
    parameter int COLUMNS = oprs_pkg::COLUMNS_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire oprs_pkg::t_cfg     i_cfg,
    input  wire logic               i_q_valid,
    input  wire oprs_pkg::t_cmd     i_q_cmd,
    output logic                    o_q_pop,
    output logic                    o_boot_clear,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output oprs_pkg::t_out_item     o_out_item
);

    localparam int BUF_SIZE = PAGES * COLUMNS;
    localparam int ADDR_W   = $clog2(BUF_SIZE);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int PAGE_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CNT_W    = oprs_pkg::RUN_CNT_W;

    // Sequencer control.
    oprs_pkg::t_bk        r_bk;
    logic                 r_boot;
    logic [ADDR_W-1:0]    r_clr_addr;

    // Display and refresh state.
    oprs_pkg::t_sys       r_sys,  n_sys;
    oprs_pkg::t_draw      r_draw, n_draw;
    logic [PAGE_W-1:0]    r_page, n_page;
    logic [COL_W-1:0]     r_col,  n_col;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic                 r_init_done, n_init_done;

    // Run being emitted.
    oprs_pkg::t_run       r_run, n_run;
    logic [CNT_W-1:0]     r_k;
    logic [PAGE_W-1:0]    r_run_page;
    logic                 r_acc,   n_acc;
    logic                 r_done,  n_done;
    logic                 r_ready, n_ready;

    // Frame buffer.
    logic [7:0]           r_mem [BUF_SIZE];
    logic [7:0]           r_rdata;
    logic                 w_rd_en;
    logic                 w_cmd_wr;
    logic                 w_wr_en;
    logic [ADDR_W-1:0]    w_wr_addr;
    logic [7:0]           w_wr_data;

    // Output register.
    logic                 r_out_valid;
    oprs_pkg::t_out_item  r_out_item;
    oprs_pkg::t_out_item  n_out_item;

    logic                 w_head_idle;
    logic                 w_detour;
    logic                 w_pop;
    logic                 w_draw_go;
    logic                 w_out_free;
    logic                 w_emit;
    logic [CNT_W-1:0]     w_len;
    logic                 w_last;

    assign w_head_idle = (r_bk == oprs_pkg::BK_IDLE) && i_q_valid;
    // The first transfer-done after init clears the buffer before it is served.
    assign w_detour    = w_head_idle && (i_q_cmd.op == oprs_pkg::OP_DONE)
                         && (r_sys == oprs_pkg::SYS_INIT);
    assign w_pop       = w_head_idle && !w_detour;
    assign o_q_pop     = w_pop;
    assign o_boot_clear = r_boot;

    // Next display state for the transaction at the head of the queue.
    always_comb begin
        n_sys       = r_sys;
        n_draw      = r_draw;
        n_page      = r_page;
        n_col       = r_col;
        n_addr      = r_addr;
        n_init_done = r_init_done;
        n_run       = oprs_pkg::RUN_NONE;
        n_acc       = 1'b0;
        n_done      = 1'b0;
        w_rd_en     = 1'b0;
        w_cmd_wr    = 1'b0;
        w_draw_go   = 1'b0;

        unique case (i_q_cmd.op)
            oprs_pkg::OP_WRITE: begin
                w_cmd_wr = i_q_cmd.wr_hit;
            end
            oprs_pkg::OP_INIT: begin
                n_run = oprs_pkg::RUN_INIT;
                n_sys = oprs_pkg::SYS_INIT;
            end
            oprs_pkg::OP_REDRAW: begin
                if (r_sys == oprs_pkg::SYS_IDLE) begin
                    n_acc     = 1'b1;
                    n_sys     = oprs_pkg::SYS_DRAW;
                    w_draw_go = 1'b1;
                end
            end
            oprs_pkg::OP_DONE: begin
                priority if (r_sys == oprs_pkg::SYS_DRAW) begin
                    w_draw_go = 1'b1;
                end else if (r_sys == oprs_pkg::SYS_DISPON) begin
                    n_run = oprs_pkg::RUN_DISPON;
                    n_sys = oprs_pkg::SYS_WAIT;
                end else if (r_sys == oprs_pkg::SYS_WAIT) begin
                    n_init_done = 1'b1;
                    n_sys       = oprs_pkg::SYS_IDLE;
                end else begin
                    n_sys = oprs_pkg::SYS_IDLE;
                end
            end
            default: begin
                n_run = oprs_pkg::RUN_NONE;
            end
        endcase

        // One refresh run: a page command run or one column's data run.
        if (w_draw_go) begin
            if (r_draw != oprs_pkg::DRW_DATA) begin
                if (r_draw == oprs_pkg::DRW_IDLE) begin
                    n_page = '0;
                    n_col  = '0;
                    n_addr = '0;
                end
                n_run  = oprs_pkg::RUN_PARAMS;
                n_draw = oprs_pkg::DRW_DATA;
            end else begin
                n_run   = oprs_pkg::RUN_DATA;
                w_rd_en = 1'b1;
                n_col   = r_col + 1'b1;
                n_addr  = r_addr + 1'b1;
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    n_col = '0;
                    if (r_page == PAGE_W'(PAGES - 1)) begin
                        n_draw = oprs_pkg::DRW_IDLE;
                        n_done = 1'b1;
                        n_sys  = r_init_done ? oprs_pkg::SYS_IDLE : oprs_pkg::SYS_DISPON;
                    end else begin
                        n_page = r_page + 1'b1;
                        n_draw = oprs_pkg::DRW_PARAMS;
                    end
                end
            end
        end

        n_ready = n_init_done && (n_sys == oprs_pkg::SYS_IDLE);
    end

    // Frame buffer write port: clearing pass or a buffer write transaction.
    assign w_wr_en   = (r_bk == oprs_pkg::BK_CLEAR) || (w_pop && w_cmd_wr);
    assign w_wr_addr = (r_bk == oprs_pkg::BK_CLEAR) ? r_clr_addr : ADDR_W'(i_q_cmd.wr_index);
    assign w_wr_data = (r_bk == oprs_pkg::BK_CLEAR) ? 8'h00 : i_q_cmd.wr_pixel;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_pop && w_rd_en) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // Length of the current run.
    always_comb begin
        unique case (r_run)
            oprs_pkg::RUN_INIT:   w_len = CNT_W'(oprs_pkg::INIT_LEN);
            oprs_pkg::RUN_PARAMS: w_len = CNT_W'(4);
            oprs_pkg::RUN_DATA:   w_len = CNT_W'(2);
            oprs_pkg::RUN_DISPON: w_len = CNT_W'(2);
            default:              w_len = CNT_W'(1);
        endcase
    end

    assign w_last     = r_k == (w_len - 1'b1);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (r_bk == oprs_pkg::BK_EMIT) && w_out_free;

    // Result for byte r_k of the current run.
    always_comb begin
        n_out_item.byte_valid       = r_run != oprs_pkg::RUN_NONE;
        n_out_item.last_byte        = w_last;
        n_out_item.request_accepted = r_acc;
        n_out_item.frame_done       = r_done;
        n_out_item.ready_res        = r_ready;
        unique case (r_run)
            oprs_pkg::RUN_INIT: begin
                n_out_item.link_byte = oprs_pkg::init_byte(r_k, i_cfg.contrast_level,
                                                           i_cfg.brightness_level);
            end
            oprs_pkg::RUN_PARAMS: begin
                unique case (r_k[1:0])
                    2'd0:    n_out_item.link_byte = oprs_pkg::CMD_STREAM;
                    2'd1:    n_out_item.link_byte = oprs_pkg::SET_PAGE | 8'(r_run_page);
                    2'd2:    n_out_item.link_byte = oprs_pkg::SET_COL_LOW
                                                    + {4'h0, i_cfg.column_offset};
                    default: n_out_item.link_byte = oprs_pkg::SET_COL_HIGH;
                endcase
            end
            oprs_pkg::RUN_DATA: begin
                n_out_item.link_byte = (r_k == '0) ? oprs_pkg::DATA_STREAM : r_rdata;
            end
            oprs_pkg::RUN_DISPON: begin
                n_out_item.link_byte = (r_k == '0) ? oprs_pkg::CMD_STREAM
                                                   : oprs_pkg::DISPLAY_ON;
            end
            default: begin
                n_out_item.link_byte = 8'h00;
            end
        endcase
    end

    // Sequencer: clearing pass, take a command, emit its run byte by byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bk        <= oprs_pkg::BK_CLEAR;
            r_boot      <= 1'b1;
            r_clr_addr  <= '0;
            r_sys       <= oprs_pkg::SYS_IDLE;
            r_draw      <= oprs_pkg::DRW_IDLE;
            r_page      <= '0;
            r_col       <= '0;
            r_addr      <= '0;
            r_init_done <= 1'b0;
            r_k         <= '0;
        end else begin
            unique case (r_bk)
                oprs_pkg::BK_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(BUF_SIZE - 1)) begin
                        r_bk   <= oprs_pkg::BK_IDLE;
                        r_boot <= 1'b0;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                oprs_pkg::BK_IDLE: begin
                    if (w_detour) begin
                        r_sys      <= oprs_pkg::SYS_DRAW;
                        r_clr_addr <= '0;
                        r_bk       <= oprs_pkg::BK_CLEAR;
                    end else if (w_pop) begin
                        r_sys       <= n_sys;
                        r_draw      <= n_draw;
                        r_page      <= n_page;
                        r_col       <= n_col;
                        r_addr      <= n_addr;
                        r_init_done <= n_init_done;
                        r_k         <= '0;
                        r_bk        <= oprs_pkg::BK_EMIT;
                    end
                end
                oprs_pkg::BK_EMIT: begin
                    if (w_emit) begin
                        r_k <= r_k + 1'b1;
                        if (w_last) begin
                            r_bk <= oprs_pkg::BK_IDLE;
                        end
                    end
                end
                default: begin
                    r_bk <= oprs_pkg::BK_IDLE;
                end
            endcase
        end
    end

    // Run descriptor captured when a command is taken.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_run      <= n_run;
            r_run_page <= n_page;
            r_acc      <= n_acc;
            r_done     <= n_done;
            r_ready    <= n_ready;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
